[design/lavm_pkg.sv]
// Shared types and constants for the look-at view matrix unit.
// Used by look_at_view_matrix and its checker; no dependencies.
package lavm_pkg;

    // Width of every coordinate on the ports
    localparam int COORD_W = 32;

    typedef logic [1:0] row_idx_t;

    // Row codes of the emitted matrix
    localparam row_idx_t ROW_X    = 2'd0;
    localparam row_idx_t ROW_Y    = 2'd1;
    localparam row_idx_t ROW_Z    = 2'd2;
    localparam row_idx_t ROW_LAST = 2'd3;

    // Camera description, one transaction per matrix
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] front_x;
        logic signed [COORD_W-1:0] front_y;
        logic signed [COORD_W-1:0] front_z;
        logic signed [COORD_W-1:0] up_x;
        logic signed [COORD_W-1:0] up_y;
        logic signed [COORD_W-1:0] up_z;
    } item_t;

    // One matrix row, four transactions per matrix
    typedef struct packed {
        row_idx_t                  row_index;
        logic signed [COORD_W-1:0] col0;
        logic signed [COORD_W-1:0] col1;
        logic signed [COORD_W-1:0] col2;
        logic signed [COORD_W-1:0] col3;
        logic                      last_row;
        logic                      degenerate;
    } row_t;

endpackage

[design/look_at_view_matrix.sv]
// Look-at view matrix: top level with cross products, translation and row output.
// Depends on lavm_pkg and lavm_norm.
//
// Accepts one camera transaction per cycle, when not stalled, into a fully
// pipelined datapath and emits four row transactions per camera, so the
// sustained camera rate is set by the row sequencer at the output; the input
// stalls only while that sequencer still holds rows of an earlier camera.
// Each of the three normalizers has an alignment depth of the ceiling of log2
// of its input width, a 32-stage square root and a FRAC_BITS+1 stage divider.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  lavm_pkg::item_t item,
    output logic            row_valid,
    input  logic            row_stall,
    output lavm_pkg::row_t  row
);

    localparam int CW  = FRAC_BITS + 2;
    localparam int PW1 = CW + 33;
    localparam int XW  = PW1 + 1;
    localparam int PW2 = 2 * CW;
    localparam int YW  = PW2 + 1;
    localparam int TW  = CW + 33;
    localparam int SDW = TW + 2;
    localparam int SW1 = 6 * 33;
    localparam int SW2 = 99 + 3 * CW + 1;
    localparam int SW3 = 99 + 6 * CW + 1;

    logic en;
    logic load;
    logic take;

    // Input stage
    logic               s0_vld_reg;
    logic signed [32:0] s0_p_reg [3];
    logic signed [32:0] s0_z_reg [3];
    logic signed [32:0] s0_u_reg [3];

    // Z axis normalizer
    logic               n1_vld;
    logic               n1_zero;
    logic signed [CW-1:0] n1_unit [3];
    logic [SW1-1:0]     n1_side;
    logic signed [32:0] n1_p [3];
    logic signed [32:0] n1_u [3];

    // First cross product
    logic                  c1_vld_reg;
    logic signed [PW1-1:0] c1_prod_reg [6];
    logic signed [32:0]    c1_p_reg [3];
    logic signed [CW-1:0]  c1_z_reg [3];
    logic                  c1_d_reg;
    logic                  x1_vld_reg;
    logic signed [XW-1:0]  x1_raw_reg [3];
    logic signed [32:0]    x1_p_reg [3];
    logic signed [CW-1:0]  x1_z_reg [3];
    logic                  x1_d_reg;

    // X axis normalizer
    logic                 n2_vld;
    logic                 n2_zero;
    logic signed [CW-1:0] n2_unit [3];
    logic [SW2-1:0]       n2_side;
    logic signed [32:0]   n2_p [3];
    logic signed [CW-1:0] n2_z [3];

    // Second cross product
    logic                  c2_vld_reg;
    logic signed [PW2-1:0] c2_prod_reg [6];
    logic signed [32:0]    c2_p_reg [3];
    logic signed [CW-1:0]  c2_z_reg [3];
    logic signed [CW-1:0]  c2_x_reg [3];
    logic                  c2_d_reg;
    logic                  y1_vld_reg;
    logic signed [YW-1:0]  y1_raw_reg [3];
    logic signed [32:0]    y1_p_reg [3];
    logic signed [CW-1:0]  y1_z_reg [3];
    logic signed [CW-1:0]  y1_x_reg [3];
    logic                  y1_d_reg;

    // Y axis normalizer
    logic                 n3_vld;
    logic                 n3_zero;
    logic signed [CW-1:0] n3_unit [3];
    logic [SW3-1:0]       n3_side;
    logic signed [32:0]   n3_p [3];
    logic signed [CW-1:0] n3_z [3];
    logic signed [CW-1:0] n3_x [3];
    logic                 n3_d;
    logic signed [CW-1:0] n3_ax [3][3];

    // Translation
    logic                  tp_vld_reg;
    logic signed [TW-1:0]  tp_prod_reg [3][3];
    logic signed [CW-1:0]  tp_ax_reg [3][3];
    logic                  tp_d_reg;
    logic                  ts_vld_reg;
    logic signed [SDW-1:0] ts_sum_reg [3];
    logic signed [CW-1:0]  ts_ax_reg [3][3];
    logic                  ts_d_reg;
    logic                  tr_vld_reg;
    logic [31:0]           tr_val_reg [3];
    logic signed [CW-1:0]  tr_ax_reg [3][3];
    logic                  tr_d_reg;
    logic [31:0]           tr_c [3];

    // Row sequencer
    logic                  hold_reg;
    lavm_pkg::row_idx_t    row_reg;
    logic signed [CW-1:0]  h_ax_reg [3][3];
    logic [31:0]           h_tr_reg [3];
    logic                  h_d_reg;

    // Advance the whole pipeline when the sequencer can take the last stage
    assign take       = hold_reg && !row_stall;
    assign en         = !tr_vld_reg || !hold_reg || (take && row_reg == lavm_pkg::ROW_LAST);
    assign load       = en && tr_vld_reg;
    assign item_stall = !en;

    // Register the input, flipping z of front and up and negating px, py
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_p_reg[0] <= -(33'(item.pos_x));
            s0_p_reg[1] <= -(33'(item.pos_y));
            s0_p_reg[2] <= 33'(item.pos_z);
            s0_z_reg[0] <= 33'(item.front_x);
            s0_z_reg[1] <= 33'(item.front_y);
            s0_z_reg[2] <= -(33'(item.front_z));
            s0_u_reg[0] <= 33'(item.up_x);
            s0_u_reg[1] <= 33'(item.up_y);
            s0_u_reg[2] <= -(33'(item.up_z));
        end
    end

    // Normalize the flipped front into the z axis
    lavm_norm #(.W(33), .F(FRAC_BITS), .SW(SW1)) u_norm_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s0_vld_reg),
        .vec      (s0_z_reg),
        .in_side  ({s0_p_reg[0], s0_p_reg[1], s0_p_reg[2],
                    s0_u_reg[0], s0_u_reg[1], s0_u_reg[2]}),
        .out_vld  (n1_vld),
        .out_zero (n1_zero),
        .unit     (n1_unit),
        .out_side (n1_side)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n1_p[k] = signed'(n1_side[SW1-1-33*k -: 33]);
            n1_u[k] = signed'(n1_side[98-33*k -: 33]);
        end
    end

    // Cross z with up: products, then differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            x1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_vld_reg <= n1_vld;
            x1_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_prod_reg[0] <= PW1'(n1_unit[1]) * PW1'(n1_u[2]);
            c1_prod_reg[1] <= PW1'(n1_unit[2]) * PW1'(n1_u[1]);
            c1_prod_reg[2] <= PW1'(n1_unit[2]) * PW1'(n1_u[0]);
            c1_prod_reg[3] <= PW1'(n1_unit[0]) * PW1'(n1_u[2]);
            c1_prod_reg[4] <= PW1'(n1_unit[0]) * PW1'(n1_u[1]);
            c1_prod_reg[5] <= PW1'(n1_unit[1]) * PW1'(n1_u[0]);
            c1_p_reg       <= n1_p;
            c1_z_reg       <= n1_unit;
            c1_d_reg       <= n1_zero;
            for (int k = 0; k < 3; k++)
                x1_raw_reg[k] <= XW'(c1_prod_reg[2*k]) - XW'(c1_prod_reg[2*k+1]);
            x1_p_reg <= c1_p_reg;
            x1_z_reg <= c1_z_reg;
            x1_d_reg <= c1_d_reg;
        end
    end

    // Normalize into the x axis
    lavm_norm #(.W(XW), .F(FRAC_BITS), .SW(SW2)) u_norm_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (x1_vld_reg),
        .vec      (x1_raw_reg),
        .in_side  ({x1_p_reg[0], x1_p_reg[1], x1_p_reg[2],
                    x1_z_reg[0], x1_z_reg[1], x1_z_reg[2], x1_d_reg}),
        .out_vld  (n2_vld),
        .out_zero (n2_zero),
        .unit     (n2_unit),
        .out_side (n2_side)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n2_p[k] = signed'(n2_side[SW2-1-33*k -: 33]);
            n2_z[k] = signed'(n2_side[3*CW-CW*k -: CW]);
        end
    end

    // Cross x with z: products, then differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_vld_reg <= 1'b0;
            y1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c2_vld_reg <= n2_vld;
            y1_vld_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_prod_reg[0] <= PW2'(n2_unit[1]) * PW2'(n2_z[2]);
            c2_prod_reg[1] <= PW2'(n2_unit[2]) * PW2'(n2_z[1]);
            c2_prod_reg[2] <= PW2'(n2_unit[2]) * PW2'(n2_z[0]);
            c2_prod_reg[3] <= PW2'(n2_unit[0]) * PW2'(n2_z[2]);
            c2_prod_reg[4] <= PW2'(n2_unit[0]) * PW2'(n2_z[1]);
            c2_prod_reg[5] <= PW2'(n2_unit[1]) * PW2'(n2_z[0]);
            c2_p_reg       <= n2_p;
            c2_z_reg       <= n2_z;
            c2_x_reg       <= n2_unit;
            c2_d_reg       <= n2_zero || n2_side[0];
            for (int k = 0; k < 3; k++)
                y1_raw_reg[k] <= YW'(c2_prod_reg[2*k]) - YW'(c2_prod_reg[2*k+1]);
            y1_p_reg <= c2_p_reg;
            y1_z_reg <= c2_z_reg;
            y1_x_reg <= c2_x_reg;
            y1_d_reg <= c2_d_reg;
        end
    end

    // Normalize into the y axis
    lavm_norm #(.W(YW), .F(FRAC_BITS), .SW(SW3)) u_norm_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (y1_vld_reg),
        .vec      (y1_raw_reg),
        .in_side  ({y1_p_reg[0], y1_p_reg[1], y1_p_reg[2],
                    y1_x_reg[0], y1_x_reg[1], y1_x_reg[2],
                    y1_z_reg[0], y1_z_reg[1], y1_z_reg[2], y1_d_reg}),
        .out_vld  (n3_vld),
        .out_zero (n3_zero),
        .unit     (n3_unit),
        .out_side (n3_side)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n3_p[k] = signed'(n3_side[SW3-1-33*k -: 33]);
            n3_x[k] = signed'(n3_side[6*CW-CW*k -: CW]);
            n3_z[k] = signed'(n3_side[3*CW-CW*k -: CW]);
        end
        n3_d     = n3_zero || n3_side[0];
        n3_ax[0] = n3_x;
        n3_ax[1] = n3_unit;
        n3_ax[2] = n3_z;
    end

    // Round each translation half away from zero and saturate to 32 bits
    always_comb
    begin
        logic [SDW-1:0] mg;
        logic [SDW-1:0] rr;
        for (int r = 0; r < 3; r++)
        begin
            mg = ts_sum_reg[r][SDW-1] ? SDW'(-ts_sum_reg[r]) : SDW'(ts_sum_reg[r]);
            rr = (mg + (SDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (ts_sum_reg[r][SDW-1])
                tr_c[r] = (rr > SDW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(~rr + 1'b1);
            else
                tr_c[r] = (rr > SDW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rr[31:0];
        end
    end

    // Dot products of each axis with the flipped position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_vld_reg <= 1'b0;
            ts_vld_reg <= 1'b0;
            tr_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            tp_vld_reg <= n3_vld;
            ts_vld_reg <= tp_vld_reg;
            tr_vld_reg <= ts_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    tp_prod_reg[r][k] <= TW'(n3_ax[r][k]) * TW'(n3_p[k]);
                ts_sum_reg[r] <= SDW'(tp_prod_reg[r][0]) + SDW'(tp_prod_reg[r][1])
                               + SDW'(tp_prod_reg[r][2]);
                tr_val_reg[r] <= tr_c[r];
            end
            tp_ax_reg <= n3_ax;
            ts_ax_reg <= tp_ax_reg;
            tr_ax_reg <= ts_ax_reg;
            tp_d_reg  <= n3_d;
            ts_d_reg  <= tp_d_reg;
            tr_d_reg  <= ts_d_reg;
        end
    end

    // Hold one finished matrix and step through its four rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            row_reg  <= lavm_pkg::ROW_X;
        end
        else if (load)
        begin
            hold_reg <= 1'b1;
            row_reg  <= lavm_pkg::ROW_X;
        end
        else if (take)
        begin
            if (row_reg == lavm_pkg::ROW_LAST)
                hold_reg <= 1'b0;
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            h_ax_reg <= tr_ax_reg;
            h_tr_reg <= tr_val_reg;
            h_d_reg  <= tr_d_reg;
        end
    end

    // Select the row on the output
    always_comb
    begin
        row.row_index  = row_reg;
        row.degenerate = h_d_reg;
        row.last_row   = (row_reg == lavm_pkg::ROW_LAST);
        unique case (row_reg)
            lavm_pkg::ROW_X:
            begin
                row.col0 = 32'(h_ax_reg[0][0]);
                row.col1 = 32'(h_ax_reg[0][1]);
                row.col2 = 32'(h_ax_reg[0][2]);
                row.col3 = h_tr_reg[0];
            end
            lavm_pkg::ROW_Y:
            begin
                row.col0 = 32'(h_ax_reg[1][0]);
                row.col1 = 32'(h_ax_reg[1][1]);
                row.col2 = 32'(h_ax_reg[1][2]);
                row.col3 = h_tr_reg[1];
            end
            lavm_pkg::ROW_Z:
            begin
                row.col0 = 32'(h_ax_reg[2][0]);
                row.col1 = 32'(h_ax_reg[2][1]);
                row.col2 = 32'(h_ax_reg[2][2]);
                row.col3 = h_tr_reg[2];
            end
            default:
            begin
                row.col0 = '0;
                row.col1 = '0;
                row.col2 = '0;
                row.col3 = 32'(1) << FRAC_BITS;
            end
        endcase
    end

    assign row_valid = hold_reg;

endmodule

[design/lavm_norm.sv]
// Pipelined vector normalizer: align, sum of squares, square root, divide.
// Instantiated by look_at_view_matrix; no package dependency.
module lavm_norm #(
    parameter int W  = 33,
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic signed [W-1:0] vec [3],
    input  logic [SW-1:0]       in_side,
    output logic                out_vld,
    output logic                out_zero,
    output logic signed [F+1:0] unit [3],
    output logic [SW-1:0]       out_side
);

    localparam int MW    = (W > 31) ? W : 31;
    localparam int NSTEP = $clog2(MW);
    localparam int SQ    = 32;
    localparam int QW    = F + 1;
    localparam int CW    = F + 2;
    localparam int DW    = F + 32;
    localparam int LAT   = NSTEP + QW + 37;
    localparam int LW    = SW + 4;

    logic [LAT-1:0]       vld_reg;
    logic [LW-1:0]        sb_reg [LAT];
    logic [MW-1:0]        al_reg [NSTEP+1][3];
    logic [30:0]          mt_reg [SQ+2][3];
    logic [61:0]          sq_reg [3];
    logic [63:0]          sx_reg [SQ+1];
    logic [63:0]          sr_reg [SQ+1];
    logic [DW-1:0]        dr_reg [QW+1][3];
    logic [QW-1:0]        dq_reg [QW+1][3];
    logic [31:0]          dl_reg [QW+1];
    logic signed [CW-1:0] u_reg  [3];
    logic [W-1:0]         mag_c  [3];
    logic [2:0]           neg_c;
    logic                 zero_c;

    // Flag zero vectors and component signs at the door
    always_comb
    begin
        zero_c = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            neg_c[i] = vec[i][W-1];
            mag_c[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
    end

    // Carry side data, zero flag and signs alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= {zero_c, neg_c, in_side};
            for (int k = 1; k < LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // Take magnitudes, then left-align so the top set bit reaches the MSB
    always_ff @(posedge clk)
    begin
        logic [MW-1:0] orv;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                al_reg[0][i] <= MW'(mag_c[i]);
            for (int j = 1; j <= NSTEP; j++)
            begin
                orv = al_reg[j-1][0] | al_reg[j-1][1] | al_reg[j-1][2];
                for (int i = 0; i < 3; i++)
                    if ((orv >> (MW - (1 << (NSTEP - j)))) == '0)
                        al_reg[j][i] <= al_reg[j-1][i] << (1 << (NSTEP - j));
                    else
                        al_reg[j][i] <= al_reg[j-1][i];
            end
        end
    end

    // Square the top 31 bits, sum, then one square-root digit per stage
    always_ff @(posedge clk)
    begin
        logic [63:0] bit_v;
        logic [63:0] rb;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mt_reg[0][i] <= al_reg[NSTEP][i][MW-1 -: 31];
                sq_reg[i]    <= 62'(al_reg[NSTEP][i][MW-1 -: 31])
                              * 62'(al_reg[NSTEP][i][MW-1 -: 31]);
            end
            sx_reg[0] <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            sr_reg[0] <= '0;
            for (int k = 1; k <= SQ + 1; k++)
                mt_reg[k] <= mt_reg[k-1];
            for (int k = 1; k <= SQ; k++)
            begin
                bit_v = 64'd1 << (64 - 2 * k);
                rb    = sr_reg[k-1] + bit_v;
                if (sx_reg[k-1] >= rb)
                begin
                    sx_reg[k] <= sx_reg[k-1] - rb;
                    sr_reg[k] <= (sr_reg[k-1] >> 1) + bit_v;
                end
                else
                begin
                    sx_reg[k] <= sx_reg[k-1];
                    sr_reg[k] <= sr_reg[k-1] >> 1;
                end
            end
        end
    end

    // Form rounded numerators, then one quotient bit per stage
    always_ff @(posedge clk)
    begin
        logic [DW-1:0] dv;
        if (en)
        begin
            dl_reg[0] <= sr_reg[SQ][31:0];
            for (int i = 0; i < 3; i++)
            begin
                dr_reg[0][i] <= (DW'(mt_reg[SQ+1][i]) << F) + DW'(sr_reg[SQ][31:1]);
                dq_reg[0][i] <= '0;
            end
            for (int j = 1; j <= QW; j++)
            begin
                dl_reg[j] <= dl_reg[j-1];
                dv = DW'(dl_reg[j-1]) << (QW - j);
                for (int i = 0; i < 3; i++)
                    if (dr_reg[j-1][i] >= dv)
                    begin
                        dr_reg[j][i] <= dr_reg[j-1][i] - dv;
                        dq_reg[j][i] <= dq_reg[j-1][i] | (QW'(1) << (QW - j));
                    end
                    else
                    begin
                        dr_reg[j][i] <= dr_reg[j-1][i];
                        dq_reg[j][i] <= dq_reg[j-1][i];
                    end
            end
        end
    end

    // Restore signs; a zero vector stays zero
    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] qs;
        if (en)
            for (int i = 0; i < 3; i++)
            begin
                qs = signed'(CW'(dq_reg[QW][i]));
                if (sb_reg[LAT-2][LW-1])
                    u_reg[i] <= '0;
                else if (sb_reg[LAT-2][SW+i])
                    u_reg[i] <= -qs;
                else
                    u_reg[i] <= qs;
            end
    end

    assign out_vld  = vld_reg[LAT-1];
    assign out_zero = sb_reg[LAT-1][LW-1];
    assign out_side = sb_reg[LAT-1][SW-1:0];
    assign unit     = u_reg;

endmodule

[design/lavm_check.sv]
// Port-level checker for look_at_view_matrix, bound to the top level.
// Depends on lavm_pkg.
module lavm_check #(
    parameter int FRAC_BITS = 16
) (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input lavm_pkg::item_t item,
    input logic            row_valid,
    input logic            row_stall,
    input lavm_pkg::row_t  row
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    // Hold a stalled camera transaction
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled camera changed");

    // Hold a stalled row
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid && $stable(row))
        else $error("stalled row changed");

    // Advance rows in order within a matrix
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row.row_index != lavm_pkg::ROW_LAST
        |=> row_valid && row.row_index == $past(row.row_index) + 2'd1)
        else $error("row sequence broken");

    // Keep the degenerate flag across one matrix
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row.row_index != lavm_pkg::ROW_LAST
        |=> row.degenerate == $past(row.degenerate))
        else $error("degenerate flag changed within a matrix");

    // Drive the fixed last row
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.row_index == lavm_pkg::ROW_LAST
        |-> row.last_row && row.col0 == '0 && row.col1 == '0
            && row.col2 == '0 && row.col3 == ONE)
        else $error("bad last row");

endmodule

bind look_at_view_matrix lavm_check #(.FRAC_BITS(FRAC_BITS)) u_lavm_check (.*);

[sim/look_at_view_matrix_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for look_at_view_matrix: random and directed cameras,
// each row checked against a built-in fixed-point predictor. Depends on lavm_pkg.
module look_at_view_matrix_tb;

    localparam int FRAC_BITS = 16;
    localparam int SETTLE_CYCLES = 400;

    typedef longint vec3_t [3];

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_stall;
    lavm_pkg::item_t item;
    logic            row_valid;
    logic            row_stall;
    lavm_pkg::row_t  row;

    lavm_pkg::row_t  expected_rows[$];
    int    errors;
    int    burst_left;

    look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row        (row)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, floor
    function automatic longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length; return 0 if it is the zero vector
    function automatic bit unit_scale(inout vec3_t v);
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        bit              neg [3];
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        len = sqrt_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            v[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // Dot product rounded half away from zero, saturated to 32 bits
    function automatic longint translation(vec3_t a, vec3_t p);
        longint          s;
        longint unsigned mg;
        longint unsigned r;
        s = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
        mg = (s < 0) ? -s : s;
        r = (mg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (s < 0)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return -longint'(r);
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return longint'(r);
    endfunction

    // Queue the four rows that a camera transaction produces
    task automatic queue_matrix_rows(lavm_pkg::item_t c);
        vec3_t          p, z, u, x, y, a;
        bit             ok;
        lavm_pkg::row_t r;
        p[0] = -longint'(c.pos_x);
        p[1] = -longint'(c.pos_y);
        p[2] = longint'(c.pos_z);
        z[0] = longint'(c.front_x);
        z[1] = longint'(c.front_y);
        z[2] = -longint'(c.front_z);
        u[0] = longint'(c.up_x);
        u[1] = longint'(c.up_y);
        u[2] = -longint'(c.up_z);
        ok = 1'b1;
        if (!unit_scale(z))
            ok = 1'b0;
        x = cross3(z, u);
        if (!unit_scale(x))
            ok = 1'b0;
        y = cross3(x, z);
        if (!unit_scale(y))
            ok = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            a = (i == 0) ? x : ((i == 1) ? y : z);
            r.row_index  = (i == 0) ? lavm_pkg::ROW_X
                         : ((i == 1) ? lavm_pkg::ROW_Y : lavm_pkg::ROW_Z);
            r.col0       = a[0][31:0];
            r.col1       = a[1][31:0];
            r.col2       = a[2][31:0];
            r.col3       = 32'(translation(a, p));
            r.last_row   = 1'b0;
            r.degenerate = !ok;
            expected_rows.push_back(r);
        end
        r.row_index  = lavm_pkg::ROW_LAST;
        r.col0       = '0;
        r.col1       = '0;
        r.col2       = '0;
        r.col3       = 32'sd1 << FRAC_BITS;
        r.last_row   = 1'b1;
        r.degenerate = !ok;
        expected_rows.push_back(r);
    endtask

    // Drop valid for an idle gap set by n, when n is positive
    task automatic idle_gap(int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Send one camera transaction, in bursts separated by random gaps
    task automatic send_camera(lavm_pkg::item_t c);
        if (burst_left == 0)
        begin
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
        end
        item       <= c;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        queue_matrix_rows(c);
        burst_left--;
    endtask

    // Hold the sender until every queued row has come back
    task automatic wait_drained();
        idle_gap(1);
        while (expected_rows.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return 32'sd0;
            2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic lavm_pkg::item_t make_camera(
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] pz, logic signed [31:0] fx,
        logic signed [31:0] fy, logic signed [31:0] fz,
        logic signed [31:0] ux, logic signed [31:0] uy,
        logic signed [31:0] uz);
        lavm_pkg::item_t c;
        c = '{px, py, pz, fx, fy, fz, ux, uy, uz};
        return c;
    endfunction

    // Corners: zero vectors, parallel front and up, extreme magnitudes, saturation
    task automatic test_directed();
        logic signed [31:0] one, mx, mn;
        one = 32'sd1 << FRAC_BITS;
        mx  = 32'sh7FFF_FFFF;
        mn  = 32'sh8000_0000;
        send_camera(make_camera(0, 0, 0, 0, 0, -one, 0, one, 0));
        send_camera(make_camera(one, 2 * one, 3 * one, 0, 0, -one, 0, one, 0));
        send_camera(make_camera(0, 0, 0, 0, 0, 0, 0, one, 0));
        send_camera(make_camera(one, one, one, one, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, 0, one, 0, 0, 2 * one, 0));
        send_camera(make_camera(0, 0, 0, one, one, one, -one, -one, -one));
        send_camera(make_camera(mx, mx, mx, one, 0, 0, 0, one, 0));
        send_camera(make_camera(mn, mn, mn, one, 0, 0, 0, one, 0));
        send_camera(make_camera(mn, mx, mn, mn, mn, mn, mx, mn, mx));
        send_camera(make_camera(mx, mn, mx, mx, mx, mx, mn, mx, mn));
        send_camera(make_camera(0, 0, 0, 1, 0, 0, 0, 0, 1));
        send_camera(make_camera(-1, -1, -1, -1, -1, 1, 1, -1, 0));
        send_camera(make_camera(mx, mx, mn, 0, 0, mn, mn, 0, 0));
        send_camera(make_camera(mn, mn, mx, mx, 0, 0, 0, 0, mx));
        send_camera(make_camera(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_8000,
                                3 * one, -one, 2 * one, 0, one, one));
        send_camera(make_camera(0, 0, 0, mn, 0, 0, mn, 0, 0));
        send_camera(make_camera('1, '1, '1, '1, '1, '1, '1, '1, '1));
        wait_drained();
    endtask

    // Random cameras; some with up parallel to front
    task automatic test_random(int n);
        lavm_pkg::item_t c;
        for (int i = 0; i < n; i++)
        begin
            c = make_camera(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord());
            if ($urandom_range(0, 15) == 0)
            begin
                c.up_x = c.front_x;
                c.up_y = c.front_y;
                c.up_z = c.front_z;
            end
            send_camera(c);
            if (i == n / 2)
                wait_drained();
        end
    endtask

    // Stall the row output on one of four patterns, re-picked at random as stall_count runs
    int stall_mode;
    int stall_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_mode  <= 0;
            stall_count <= 0;
            row_stall   <= 1'b0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: row_stall <= 1'b0;
                1: row_stall <= 1'($urandom_range(0, 1));
                2: row_stall <= ($urandom_range(0, 7) != 0);
                default: row_stall <= (stall_count % 8) < 3;
            endcase
        end
    end

    // Compare each accepted row with the oldest expected row
    always @(posedge clk)
    begin
        lavm_pkg::row_t e;
        if (rst_n && row_valid && !row_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row transaction: row_index %0d", row.row_index);
                errors++;
            end
            else
            begin
                e = expected_rows.pop_front();
                if (row.row_index !== e.row_index)
                begin
                    $error("row_index expected %0d actual %0d", e.row_index, row.row_index);
                    errors++;
                end
                if (row.col0 !== e.col0)
                begin
                    $error("col0 expected %0d actual %0d", e.col0, row.col0);
                    errors++;
                end
                if (row.col1 !== e.col1)
                begin
                    $error("col1 expected %0d actual %0d", e.col1, row.col1);
                    errors++;
                end
                if (row.col2 !== e.col2)
                begin
                    $error("col2 expected %0d actual %0d", e.col2, row.col2);
                    errors++;
                end
                if (row.col3 !== e.col3)
                begin
                    $error("col3 expected %0d actual %0d", e.col3, row.col3);
                    errors++;
                end
                if (row.last_row !== e.last_row)
                begin
                    $error("last_row expected %0d actual %0d", e.last_row, row.last_row);
                    errors++;
                end
                if (row.degenerate !== e.degenerate)
                begin
                    $error("degenerate expected %0d actual %0d", e.degenerate,
                           row.degenerate);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Main sequence
    initial
    begin
        errors     = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(340);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_rows.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
